// ===== hw/rtl/dmxrx_pkg.sv =====
package dmxrx_pkg;

  localparam int BYTE_W = 8;
  localparam int SLOT_W = 10;
  localparam int RATE_W = 16;
  localparam int MASK_W = 4;
  localparam int PORT_W = 2;

  typedef enum logic [2:0] {
    OP_LINE_BREAK  = 3'd0,
    OP_RX_BYTE     = 3'd1,
    OP_END_FRAME   = 3'd2,
    OP_SECOND_TICK = 3'd3,
    OP_TAKE_FRAME  = 3'd4,
    OP_READ_SLOT   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RX_IDLE      = 2'd0,
    RX_PRE_BREAK = 2'd1,
    RX_BREAK     = 2'd2,
    RX_DATA      = 2'd3
  } rx_state_e;

  typedef struct packed {
    op_e               op;
    logic [PORT_W-1:0] port;
    logic [BYTE_W-1:0] data_byte;
    logic [SLOT_W-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic              frame_available;
    logic [BYTE_W-1:0] slot_data;
    logic [SLOT_W-1:0] slots_in_frame;
    logic [RATE_W-1:0] updates_per_second;
    logic              frame_committed;
    rx_state_e         receive_state;
  } out_t;

endpackage

// ===== hw/rtl/dmxrx_ram.sv =====
module dmxrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8208
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmx512_frame_receiver.sv =====
// Multi-port DMX512 frame receiver. One transaction is accepted per cycle while the
// result side keeps up; each result passes through the s1 and output registers, with
// its slot byte from the registered read port of the frame byte RAM. Every transaction
// gives exactly one result. Frame bytes live in one single-port-write RAM of
// PORT_COUNT * RING_FRAMES * (MAX_SLOTS + 1) bytes; per-port state, ring pointers,
// slot counts and rate counters are flip-flops cleared by reset. Reading a slot that
// was never written returns an undefined byte. Write the enable mask only while idle.
module dmx512_frame_receiver #(
  parameter int PORT_COUNT  = 4,
  parameter int RING_FRAMES = 4,
  parameter int MAX_SLOTS   = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dmxrx_pkg::MASK_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  dmxrx_pkg::in_t              in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dmxrx_pkg::out_t             out_item_o
);

  localparam int PW        = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int RW        = $clog2(RING_FRAMES);
  localparam int CW        = $clog2(PORT_COUNT * RING_FRAMES);
  localparam int FRAME_LEN = MAX_SLOTS + 1;
  localparam int MEM_DEPTH = PORT_COUNT * RING_FRAMES * FRAME_LEN;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SW        = dmxrx_pkg::SLOT_W;
  localparam int BW        = dmxrx_pkg::BYTE_W;
  localparam int TW        = dmxrx_pkg::RATE_W;

  // per-port state
  dmxrx_pkg::rx_state_e  state_q  [PORT_COUNT];
  logic [SW-1:0]         wslot_q  [PORT_COUNT];
  logic [RW-1:0]         head_q   [PORT_COUNT];
  logic [RW-1:0]         tail_q   [PORT_COUNT];
  logic [RW-1:0]         taken_q  [PORT_COUNT];
  logic [TW-1:0]         pcnt_q   [PORT_COUNT];
  logic [TW-1:0]         plast_q  [PORT_COUNT];
  logic [TW-1:0]         rate_q   [PORT_COUNT];
  logic [SW-1:0]         counts_q [PORT_COUNT * RING_FRAMES];
  logic [dmxrx_pkg::MASK_W-1:0] mask_q;

  // pipeline
  logic            s1_valid_q;
  dmxrx_pkg::out_t s1_item_q;
  logic            s1_rd_q;
  logic            out_valid_q;
  dmxrx_pkg::out_t out_item_q;
  dmxrx_pkg::out_t out_item_d;
  logic            s1_adv;
  logic            accept;

  // per-transaction logic
  logic [PW-1:0]        pidx;
  logic                 port_ok;
  logic                 port_en;
  logic                 tick;
  dmxrx_pkg::rx_state_e st_cur, st_d;
  logic [SW-1:0]        ws_cur, ws_d, ws_clip;
  logic [RW-1:0]        head_cur, head_d, tail_cur, tail_d, taken_cur, taken_d;
  logic [TW-1:0]        pc_d, rate_out;
  logic                 commit, avail, mem_we, rd_hit;
  logic [SW-1:0]        cnt_val, slots_out;
  logic [SW-1:0]        mem_wslot;
  logic [BW-1:0]        mem_wdata;
  logic [CW-1:0]        cidx_w, cidx_r, cidx_t;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [BW-1:0]        ram_rdata;
  logic                 ram_we, ram_re;
  dmxrx_pkg::out_t      res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign pidx     = PW'({{PW{1'b0}}, in_item_i.port});
  assign port_ok  = 32'(in_item_i.port) < PORT_COUNT;
  assign port_en  = mask_q[in_item_i.port];
  assign tick     = in_item_i.op == dmxrx_pkg::OP_SECOND_TICK;
  assign st_cur   = state_q[pidx];
  assign ws_cur   = wslot_q[pidx];
  assign head_cur = head_q[pidx];
  assign tail_cur = tail_q[pidx];
  assign taken_cur = taken_q[pidx];
  assign ws_clip  = (ws_cur > SW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : ws_cur;

  always_comb begin
    st_d      = st_cur;
    ws_d      = ws_cur;
    head_d    = head_cur;
    tail_d    = tail_cur;
    taken_d   = taken_cur;
    pc_d      = pcnt_q[pidx];
    commit    = 1'b0;
    cnt_val   = '0;
    avail     = 1'b0;
    mem_we    = 1'b0;
    mem_wslot = '0;
    mem_wdata = '0;
    rd_hit    = 1'b0;
    case (in_item_i.op)
      dmxrx_pkg::OP_LINE_BREAK: begin
        if (port_en) begin
          st_d = dmxrx_pkg::RX_PRE_BREAK;
        end
      end
      dmxrx_pkg::OP_RX_BYTE: begin
        if (port_en) begin
          case (st_cur)
            dmxrx_pkg::RX_PRE_BREAK: st_d = dmxrx_pkg::RX_BREAK;
            dmxrx_pkg::RX_BREAK: begin
              if (in_item_i.data_byte == '0) begin
                st_d   = dmxrx_pkg::RX_DATA;
                mem_we = 1'b1;
                ws_d   = SW'(1);
                pc_d   = pcnt_q[pidx] + 1'b1;
              end else begin
                st_d = dmxrx_pkg::RX_IDLE;
              end
            end
            dmxrx_pkg::RX_DATA: begin
              mem_we    = 1'b1;
              mem_wslot = ws_clip;
              mem_wdata = in_item_i.data_byte;
              ws_d      = ws_clip + 1'b1;
              if (ws_clip == SW'(MAX_SLOTS)) begin
                commit  = 1'b1;
                cnt_val = SW'(MAX_SLOTS);
              end
            end
            default: ;
          endcase
        end
      end
      dmxrx_pkg::OP_END_FRAME: begin
        if (port_en && st_cur == dmxrx_pkg::RX_DATA) begin
          commit  = 1'b1;
          cnt_val = (ws_cur != '0) ? ws_cur - 1'b1 : '0;
        end
      end
      dmxrx_pkg::OP_TAKE_FRAME: begin
        if (head_cur != tail_cur) begin
          taken_d = tail_cur;
          tail_d  = (tail_cur == RW'(RING_FRAMES - 1)) ? '0 : tail_cur + 1'b1;
          avail   = 1'b1;
        end
      end
      dmxrx_pkg::OP_READ_SLOT: begin
        rd_hit = in_item_i.slot_index <= SW'(MAX_SLOTS);
      end
      default: ;
    endcase
    if (commit) begin
      head_d = (head_cur == RW'(RING_FRAMES - 1)) ? '0 : head_cur + 1'b1;
      st_d   = dmxrx_pkg::RX_IDLE;
    end
  end

  assign cidx_w = CW'(CW'(pidx) * CW'(RING_FRAMES) + CW'(head_cur));
  assign cidx_r = CW'(CW'(pidx) * CW'(RING_FRAMES) + CW'(taken_cur));
  assign cidx_t = CW'(CW'(pidx) * CW'(RING_FRAMES) + CW'(taken_d));

  assign ram_we    = accept && port_ok && mem_we;
  assign ram_re    = accept && port_ok && rd_hit;
  assign ram_waddr = AW'(AW'(cidx_w) * AW'(FRAME_LEN) + AW'(mem_wslot));
  assign ram_raddr = AW'(AW'(cidx_r) * AW'(FRAME_LEN) + AW'(in_item_i.slot_index));

  assign slots_out = (commit && head_cur == taken_d) ? cnt_val : counts_q[cidx_t];
  assign rate_out  = tick ? pcnt_q[pidx] - plast_q[pidx] : rate_q[pidx];

  always_comb begin
    res = '0;
    if (port_ok) begin
      res.frame_available    = avail;
      res.slots_in_frame     = slots_out;
      res.updates_per_second = rate_out;
      res.frame_committed    = commit;
      res.receive_state      = st_d;
    end
  end

  dmxrx_ram #(
    .WIDTH(BW),
    .DEPTH(MEM_DEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(mem_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int q = 0; q < PORT_COUNT; q++) begin
        state_q[q] <= dmxrx_pkg::RX_IDLE;
        wslot_q[q] <= '0;
        head_q[q]  <= '0;
        tail_q[q]  <= '0;
        taken_q[q] <= '0;
        pcnt_q[q]  <= '0;
        plast_q[q] <= '0;
        rate_q[q]  <= '0;
      end
      for (int c = 0; c < PORT_COUNT * RING_FRAMES; c++) begin
        counts_q[c] <= '0;
      end
    end else begin
      if (accept) begin
        if (tick) begin
          for (int q = 0; q < PORT_COUNT; q++) begin
            rate_q[q]  <= pcnt_q[q] - plast_q[q];
            plast_q[q] <= pcnt_q[q];
          end
        end
        if (port_ok) begin
          state_q[pidx] <= st_d;
          wslot_q[pidx] <= ws_d;
          head_q[pidx]  <= head_d;
          tail_q[pidx]  <= tail_d;
          taken_q[pidx] <= taken_d;
          pcnt_q[pidx]  <= pc_d;
          if (commit) begin
            counts_q[cidx_w] <= cnt_val;
          end
        end
      end
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
        for (int q = 0; q < PORT_COUNT; q++) begin
          if (q >= dmxrx_pkg::MASK_W || !cfg_wdata_i[q[1:0]]) begin
            state_q[q] <= dmxrx_pkg::RX_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  always_comb begin
    out_item_d           = s1_item_q;
    out_item_d.slot_data = s1_rd_q ? ram_rdata : '0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= res;
      s1_rd_q   <= ram_re;
    end
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hw/rtl/dmxrx_checker.sv =====
module dmxrx_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input dmxrx_pkg::out_t out_item_o
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // a commit always leaves the port idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_committed |->
      out_item_o.receive_state == dmxrx_pkg::RX_IDLE)
    else $error("commit without idle state");

  // take and commit come from different ops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.frame_available && out_item_o.frame_committed))
    else $error("take and commit in one result");

  // slot data only on a read, which never commits or takes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.slot_data != '0 |->
      !out_item_o.frame_available && !out_item_o.frame_committed)
    else $error("slot data on a non-read result");

endmodule

bind dmx512_frame_receiver dmxrx_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

// ===== sim/dmx512_frame_checker.sv =====
`timescale 1ns / 100ps

module dmx512_frame_checker #(
  parameter int PORTS     = 4,
  parameter int RING      = 4,
  parameter int MAX_SLOTS = 512
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [dmxrx_pkg::MASK_W-1:0]                 cfg_wdata_i,
  input  logic                                         in_valid_i,
  input  logic                                         in_stall_i,
  input  dmxrx_pkg::in_t                               in_item_i,
  input  logic                                         out_valid_i,
  input  logic                                         out_stall_i,
  input  dmxrx_pkg::out_t                              out_item_i,
  output logic [PORTS-1:0][dmxrx_pkg::SLOT_W-1:0]      readable_slots_o,
  output int                                           pending_o,
  output int                                           fail_count_o
);
  import dmxrx_pkg::*;

  logic [MASK_W-1:0] enable_mask;
  rx_state_e         rx_state     [PORTS];
  logic [SLOT_W-1:0] next_slot    [PORTS];
  logic [1:0]        head         [PORTS];
  logic [1:0]        tail         [PORTS];
  logic [1:0]        taken        [PORTS];
  logic [BYTE_W-1:0] frame_mem    [PORTS][RING][MAX_SLOTS+1];
  logic [SLOT_W-1:0] written_len  [PORTS][RING];
  logic [SLOT_W-1:0] slot_count   [PORTS][RING];
  logic [RATE_W-1:0] started      [PORTS];
  logic [RATE_W-1:0] started_last [PORTS];
  logic [RATE_W-1:0] rate         [PORTS];
  out_t              expected_q   [$];

  // frames are written from slot 0 upwards, so the written part is a prefix
  function automatic void store_byte(int unsigned p, int unsigned slot, logic [BYTE_W-1:0] b);
    frame_mem[p][head[p]][slot] = b;
    if (written_len[p][head[p]] < slot + 1)
      written_len[p][head[p]] = slot + 1;
  endfunction

  function automatic void close_frame(int unsigned p, int unsigned count);
    slot_count[p][head[p]] = count;
    head[p] = head[p] + 2'd1;
    rx_state[p] = RX_IDLE;
  endfunction

  function automatic out_t predict_transaction(in_t it);
    int unsigned p;
    int unsigned w;
    int unsigned q;
    out_t r;
    p = it.port;
    r = '0;
    if (it.op == OP_SECOND_TICK) begin
      for (q = 0; q < PORTS; q++) begin
        rate[q] = started[q] - started_last[q];
        started_last[q] = started[q];
      end
    end
    if (it.op <= OP_END_FRAME && enable_mask[p]) begin
      case (it.op)
        OP_LINE_BREAK: rx_state[p] = RX_PRE_BREAK;
        OP_RX_BYTE: begin
          case (rx_state[p])
            RX_PRE_BREAK: rx_state[p] = RX_BREAK;
            RX_BREAK: begin
              if (it.data_byte == '0) begin
                rx_state[p] = RX_DATA;
                store_byte(p, 0, '0);
                next_slot[p] = 1;
                started[p] = started[p] + 1'b1;
              end else begin
                rx_state[p] = RX_IDLE;
              end
            end
            RX_DATA: begin
              w = (next_slot[p] > MAX_SLOTS) ? MAX_SLOTS : next_slot[p];
              store_byte(p, w, it.data_byte);
              next_slot[p] = w + 1;
              if (w + 1 > MAX_SLOTS) begin
                close_frame(p, MAX_SLOTS);
                r.frame_committed = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: begin
          if (rx_state[p] == RX_DATA) begin
            close_frame(p, (next_slot[p] > 0) ? next_slot[p] - 1 : 0);
            r.frame_committed = 1'b1;
          end
        end
      endcase
    end else if (it.op == OP_TAKE_FRAME) begin
      if (head[p] != tail[p]) begin
        taken[p] = tail[p];
        tail[p] = tail[p] + 2'd1;
        r.frame_available = 1'b1;
      end
    end else if (it.op == OP_READ_SLOT && it.slot_index <= MAX_SLOTS) begin
      r.slot_data = frame_mem[p][taken[p]][it.slot_index];
    end
    r.slots_in_frame     = slot_count[p][taken[p]];
    r.updates_per_second = rate[p];
    r.receive_state      = rx_state[p];
    return r;
  endfunction

  function automatic void check_field(string name, logic [RATE_W-1:0] want,
                                      logic [RATE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int unsigned p;
    int unsigned f;
    if (!rst_ni) begin
      enable_mask = '0;
      for (p = 0; p < PORTS; p++) begin
        rx_state[p]     = RX_IDLE;
        next_slot[p]    = '0;
        head[p]         = '0;
        tail[p]         = '0;
        taken[p]        = '0;
        started[p]      = '0;
        started_last[p] = '0;
        rate[p]         = '0;
        for (f = 0; f < RING; f++) begin
          written_len[p][f] = '0;
          slot_count[p][f]  = '0;
        end
      end
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("frame_available", want.frame_available, out_item_i.frame_available);
          check_field("slot_data", want.slot_data, out_item_i.slot_data);
          check_field("slots_in_frame", want.slots_in_frame, out_item_i.slots_in_frame);
          check_field("updates_per_second", want.updates_per_second,
                      out_item_i.updates_per_second);
          check_field("frame_committed", want.frame_committed, out_item_i.frame_committed);
          check_field("receive_state", want.receive_state, out_item_i.receive_state);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_transaction(in_item_i));
      if (cfg_we_i) begin
        enable_mask = cfg_wdata_i;
        for (p = 0; p < PORTS; p++)
          if (!enable_mask[p])
            rx_state[p] = RX_IDLE;
      end
    end
    pending_o = expected_q.size();
    for (p = 0; p < PORTS; p++)
      readable_slots_o[p] = written_len[p][taken[p]];
  end

endmodule

// ===== sim/tb_dmx512_frame_receiver.sv =====
`timescale 1ns / 100ps

module tb_dmx512_frame_receiver;
  import dmxrx_pkg::*;

  localparam int  PORTS        = 4;
  localparam int  MAX_SLOTS    = 512;
  localparam int  SLOT_TOP     = (1 << SLOT_W) - 1;
  localparam int  DEAD_LIMIT   = 2000;
  localparam int  SETTLE       = 4;
  localparam int  BURST_FRAMES = 20;
  localparam op_e OP_SPARE_LO  = op_e'(3'd6);
  localparam op_e OP_SPARE_HI  = op_e'(3'd7);

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [MASK_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_t               in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_item_o;

  logic [PORTS-1:0][SLOT_W-1:0] readable_slots;
  int          pending;
  int          fail_count;
  bit          idle_on     = 1'b1;
  bit          quiet       = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned dead_cycles = 0;
  int unsigned sent        = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dmx512_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  dmx512_frame_checker #(.PORTS(PORTS), .MAX_SLOTS(MAX_SLOTS)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .readable_slots_o (readable_slots),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && !quiet && !out_stall_i && $urandom_range(3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= DEAD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  function automatic in_t item(op_e op, logic [PORT_W-1:0] port,
                               logic [BYTE_W-1:0] b = '0, logic [SLOT_W-1:0] si = '0);
    in_t it;
    it.op         = op;
    it.port       = port;
    it.data_byte  = b;
    it.slot_index = si;
    return it;
  endfunction

  function automatic in_t random_item();
    return item(op_e'($urandom_range(7)), PORT_W'($urandom_range(PORTS - 1)),
                BYTE_W'($urandom_range(255)), SLOT_W'($urandom_range(SLOT_TOP)));
  endfunction

  // runs from a falling edge to the falling edge after acceptance
  task automatic send(input in_t it);
    int unsigned gap;
    gap = (idle_on && !quiet && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    // never read a slot of the taken frame that has not been written
    if (it.op == OP_READ_SLOT && it.slot_index <= MAX_SLOTS &&
        it.slot_index >= readable_slots[it.port])
      it.slot_index = (readable_slots[it.port] == 0) ?
                      SLOT_W'($urandom_range(SLOT_TOP, MAX_SLOTS + 1)) :
                      SLOT_W'($urandom_range(readable_slots[it.port] - 1));
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_mask(input logic [MASK_W-1:0] mask);
    drain();
    cfg_wdata_i <= mask;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_frame(input logic [PORT_W-1:0] p, input int unsigned n);
    in_t         seq[$];
    in_t         extra;
    int unsigned i;
    seq.push_back(item(OP_LINE_BREAK, p, BYTE_W'($urandom_range(255))));
    if ($urandom_range(7) == 0)
      seq.push_back(item(OP_LINE_BREAK, p));
    seq.push_back(item(OP_RX_BYTE, p, BYTE_W'($urandom_range(255))));
    seq.push_back(item(OP_RX_BYTE, p,
                       ($urandom_range(7) == 0) ? BYTE_W'($urandom_range(255, 1)) : '0));
    for (i = 0; i < n; i++)
      seq.push_back(item(OP_RX_BYTE, p, BYTE_W'($urandom_range(255)),
                         SLOT_W'($urandom_range(SLOT_TOP))));
    if ($urandom_range(5) != 0)
      seq.push_back(item(OP_END_FRAME, p, BYTE_W'($urandom_range(255))));
    foreach (seq[k]) begin
      if ($urandom_range(7) == 0) begin
        extra = random_item();
        extra.port = p ^ PORT_W'($urandom_range(3, 1));
        send(extra);
      end
      send(seq[k]);
    end
  endtask

  task automatic take_and_read(input logic [PORT_W-1:0] p);
    send(item(OP_TAKE_FRAME, p, BYTE_W'($urandom_range(255)), SLOT_W'($urandom_range(SLOT_TOP))));
    repeat ($urandom_range(4, 1))
      send(item(OP_READ_SLOT, p, BYTE_W'($urandom_range(255)),
                ($urandom_range(4) == 0) ? SLOT_W'($urandom_range(SLOT_TOP)) :
                                           SLOT_W'($urandom_range(MAX_SLOTS))));
  endtask

  task automatic random_phase(input logic [MASK_W-1:0] mask, input int unsigned count,
                              input bit last);
    int unsigned base;
    int unsigned pick;
    logic [PORT_W-1:0] p;
    set_mask(mask);
    quiet = last;
    base  = sent;
    while (sent - base < count) begin
      if ($urandom_range(29) == 0)
        idle_on = !idle_on;
      pick = $urandom_range(19);
      p    = PORT_W'($urandom_range(PORTS - 1));
      if (pick <= 10)
        send_frame(p, ($urandom_range(29) == 0) ? $urandom_range(200, 21) : $urandom_range(20));
      else if (pick <= 14)
        take_and_read(p);
      else if (pick == 15)
        send(item(OP_SECOND_TICK, p, BYTE_W'($urandom_range(255))));
      else
        send(random_item());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_mask(4'hF);
    send(item(OP_SECOND_TICK, 2'd3, 8'hFF, SLOT_W'(SLOT_TOP)));
    send(item(OP_READ_SLOT, 2'd0, 8'h00, SLOT_W'(SLOT_TOP)));
    send(item(OP_TAKE_FRAME, 2'd0));
    send(item(OP_END_FRAME, 2'd0));
    send(item(OP_LINE_BREAK, 2'd0));
    send(item(OP_RX_BYTE, 2'd0, 8'hFF));
    send(item(OP_RX_BYTE, 2'd0, 8'h00));
    send(item(OP_RX_BYTE, 2'd0, 8'hFF));
    send(item(OP_RX_BYTE, 2'd0, 8'h00));
    send(item(OP_RX_BYTE, 2'd0, 8'hA5));
    send(item(OP_END_FRAME, 2'd0));
    send(item(OP_TAKE_FRAME, 2'd0));
    send(item(OP_READ_SLOT, 2'd0, 8'h00, 10'd0));
    send(item(OP_READ_SLOT, 2'd0, 8'h00, 10'd3));
    send(item(OP_SECOND_TICK, 2'd0));
    send(item(OP_LINE_BREAK, 2'd1));
    send(item(OP_LINE_BREAK, 2'd1));
    send(item(OP_RX_BYTE, 2'd1, 8'h12));
    send(item(OP_RX_BYTE, 2'd1, 8'h55));
    send(item(OP_RX_BYTE, 2'd1, 8'h00));
    send(item(OP_SPARE_LO, 2'd2));
    send(item(OP_SPARE_HI, 2'd3));

    // port 2 loses its enable part way through a frame
    send(item(OP_LINE_BREAK, 2'd2));
    send(item(OP_RX_BYTE, 2'd2, 8'h81));
    send(item(OP_RX_BYTE, 2'd2, 8'h00));
    send(item(OP_RX_BYTE, 2'd2, 8'h3C));
    set_mask(4'b1011);
    send(item(OP_END_FRAME, 2'd2));
    set_mask(4'h0);
    send(item(OP_LINE_BREAK, 2'd0));
    send(item(OP_RX_BYTE, 2'd0, 8'h00));
    send(item(OP_TAKE_FRAME, 2'd1));
    set_mask(4'hF);
    send(item(OP_END_FRAME, 2'd2));

    // full-length frame commits itself on the last slot
    send(item(OP_LINE_BREAK, 2'd3));
    send(item(OP_RX_BYTE, 2'd3, 8'h7E));
    send(item(OP_RX_BYTE, 2'd3, 8'h00));
    repeat (MAX_SLOTS) send(item(OP_RX_BYTE, 2'd3, BYTE_W'($urandom_range(255))));
    send(item(OP_RX_BYTE, 2'd3, 8'hC3));
    send(item(OP_TAKE_FRAME, 2'd3));
    send(item(OP_READ_SLOT, 2'd3, 8'h00, SLOT_W'(MAX_SLOTS)));
    send(item(OP_READ_SLOT, 2'd3, 8'h00, 10'd0));

    // a burst of frame starts between two ticks
    idle_on = 1'b0;
    send(item(OP_SECOND_TICK, 2'd1));
    repeat (BURST_FRAMES) begin
      send(item(OP_LINE_BREAK, 2'd1));
      send(item(OP_RX_BYTE, 2'd1, BYTE_W'($urandom_range(255))));
      send(item(OP_RX_BYTE, 2'd1, 8'h00));
    end
    send(item(OP_SECOND_TICK, 2'd2));
    send(item(OP_TAKE_FRAME, 2'd1));
    idle_on = 1'b1;

    random_phase(4'hF, 60, 1'b0);
    random_phase(4'b0110, 40, 1'b0);
    random_phase(MASK_W'($urandom_range(15)), 40, 1'b0);
    random_phase(4'b1001, 40, 1'b0);
    random_phase(4'hF, 50, 1'b1);

    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
